// ===== hdl/utf8_char_ngram_extractor_defines.svh =====
// Assertion macros shared by the n-gram extractor RTL.
`ifndef UTF8_CHAR_NGRAM_EXTRACTOR_DEFINES_SVH
`define UTF8_CHAR_NGRAM_EXTRACTOR_DEFINES_SVH

// Clocked assertion, masked while reset is asserted (active-low reset).
`define UCNE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define UCNE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/ucne_pkg.sv =====
// Package: widths and constants of the UTF-8 character n-gram extractor.
package ucne_pkg;

  localparam int MAX_GRAM  = 6;
  localparam int WIN_DEPTH = MAX_GRAM - 1;
  localparam int FILL_W    = $clog2(MAX_GRAM);
  localparam int CP_FIELDS = 6;
  localparam int CP_W      = 21;
  localparam int GLEN_W    = 3;

  localparam logic [GLEN_W-1:0] GLEN_RESET = 3'd3;

  // UTF-8 lead byte class bounds
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Sequence lengths
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  // Code point range limits
  localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;

  // C-locale whitespace test on the low byte
  function automatic logic is_space(input logic [7:0] b);
    return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
  endfunction

endpackage

// ===== hdl/utf8_char_ngram_extractor.sv =====
// Top level: UTF-8 decoder, space collapsing and sliding n-gram window.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  in       | input     | in_valid_i / in_ready_o   | data_byte, byte_present, end_of_string
//  out      | output    | out_valid_o / out_ready_i | gram_valid, code_point_0..5, string_done,
//           |           |                           | decode_failed
//  cfg      | input     | cfg_valid_i / cfg_ready_o | gram_length (cfg_data_i)
//
// One byte per cycle unless a full result stalls: decode and window update are one level of
// logic before the result register; a result shows the cycle after its request is taken.
// The input is ready whenever the result register is empty or is being drained.
// A stalled output holds its result and blocks new requests only while it is full.
// Reset (rst_ni low, asynchronous) empties the string state and sets gram_length to 3.
`include "utf8_char_ngram_extractor_defines.svh"

module utf8_char_ngram_extractor
  import ucne_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input requests
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              end_of_string_i,
  // results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              gram_valid_o,
  output logic [CP_W-1:0]   code_point_0_o,
  output logic [CP_W-1:0]   code_point_1_o,
  output logic [CP_W-1:0]   code_point_2_o,
  output logic [CP_W-1:0]   code_point_3_o,
  output logic [CP_W-1:0]   code_point_4_o,
  output logic [CP_W-1:0]   code_point_5_o,
  output logic              string_done_o,
  output logic              decode_failed_o,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [GLEN_W-1:0] cfg_data_i
);

  // state
  logic [GLEN_W-1:0] gram_len_q, gram_len_d;
  logic [CP_W-1:0]   partial_q, partial_d;
  logic [1:0]        exp_q, exp_d;
  logic [2:0]        seq_q, seq_d;
  logic [CP_W-1:0]   win_q [WIN_DEPTH];
  logic [CP_W-1:0]   win_d [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              prev_sp_q, prev_sp_d;
  logic              aborted_q, aborted_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              gram_valid_q;
  logic [CP_W-1:0]   out_cp_q [CP_FIELDS];
  logic              done_q;
  logic              failed_q;

  // combinational results
  logic              in_acc;
  logic              byte_go;
  logic              cp_ok;
  logic [CP_W-1:0]   cp_val;
  logic [CP_W-1:0]   acc;
  logic              sp;
  logic              have_gram;
  logic              emit;
  logic              failed;
  logic [CP_W-1:0]   gram_cp [CP_FIELDS];
  logic [3:0]        fill_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign byte_go     = in_acc && byte_present_i && !aborted_q;
  assign acc         = {partial_q[CP_W-7:0], data_byte_i[5:0]};
  assign fill_inc    = {1'b0, fill_q} + 4'd1;

  // decode, collapse spaces, slide the window, close strings and take config writes
  always_comb begin
    partial_d = partial_q;
    exp_d     = exp_q;
    seq_d     = seq_q;
    win_d     = win_q;
    fill_d    = fill_q;
    prev_sp_d = prev_sp_q;
    aborted_d = aborted_q;
    gram_len_d = gram_len_q;
    cp_ok     = 1'b0;
    cp_val    = '0;
    have_gram = 1'b0;
    failed    = 1'b0;
    for (int k = 0; k < CP_FIELDS; k++) begin
      gram_cp[k] = '0;
    end

    // byte decoder
    if (byte_go) begin
      if (exp_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          cp_ok  = 1'b1;
          cp_val = {{(CP_W-8){1'b0}}, data_byte_i};
        end else if (data_byte_i >= LEAD2_LO && data_byte_i <= LEAD2_HI) begin
          partial_d = {{(CP_W-5){1'b0}}, data_byte_i[4:0]};
          exp_d     = 2'd1;
          seq_d     = SEQ_TWO;
        end else if (data_byte_i >= LEAD3_LO && data_byte_i <= LEAD3_HI) begin
          partial_d = {{(CP_W-4){1'b0}}, data_byte_i[3:0]};
          exp_d     = 2'd2;
          seq_d     = SEQ_THREE;
        end else if (data_byte_i >= LEAD4_LO && data_byte_i <= LEAD4_HI) begin
          partial_d = {{(CP_W-3){1'b0}}, data_byte_i[2:0]};
          exp_d     = 2'd3;
          seq_d     = SEQ_FOUR;
        end else begin
          aborted_d = 1'b1;
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        aborted_d = 1'b1;
      end else begin
        partial_d = acc;
        exp_d     = exp_q - 2'd1;
        if (exp_q == 2'd1) begin
          // overlong, surrogate and out-of-range checks
          if ((seq_q == SEQ_THREE && (acc < MIN_CP3 || (acc >= SURR_LO && acc <= SURR_HI))) ||
              (seq_q == SEQ_FOUR && (acc < MIN_CP4 || acc > MAX_CP))) begin
            aborted_d = 1'b1;
          end else begin
            seq_d     = SEQ_NONE;
            partial_d = '0;
            cp_ok     = 1'b1;
            cp_val    = acc;
          end
        end
      end
    end

    // keep the code point unless it is NUL (abort) or repeats a space (tested on its low byte)
    sp = is_space(cp_val[7:0]);
    if (cp_ok) begin
      if (cp_val == '0) begin
        aborted_d = 1'b1;
      end else if (!(sp && prev_sp_q)) begin
        prev_sp_d = sp;
        if (gram_len_q != '0) begin
          if (fill_inc < {1'b0, gram_len_q}) begin
            win_d[fill_q] = cp_val;
            fill_d        = fill_inc[FILL_W-1:0];
          end else begin
            have_gram = 1'b1;
            for (int k = 0; k < CP_FIELDS; k++) begin
              if (k + 1 < int'(gram_len_q)) begin
                if (k < WIN_DEPTH) gram_cp[k] = win_q[k];
              end else if (k + 1 == int'(gram_len_q)) begin
                gram_cp[k] = cp_val;
              end
            end
            for (int k = 0; k < WIN_DEPTH; k++) begin
              if (k + 2 < int'(gram_len_q)) begin
                if (k + 1 < WIN_DEPTH) win_d[k] = win_q[k + 1];
              end else if (k + 2 == int'(gram_len_q)) begin
                win_d[k] = cp_val;
              end
            end
          end
        end
      end
    end

    // end of string: report and clear
    if (in_acc && end_of_string_i) begin
      failed    = aborted_d || (exp_d != 2'd0);
      partial_d = '0;
      exp_d     = 2'd0;
      seq_d     = SEQ_NONE;
      fill_d    = '0;
      prev_sp_d = 1'b0;
      aborted_d = 1'b0;
    end

    // register write; out-of-range values are dropped
    if (cfg_valid_i && (int'(cfg_data_i) <= MAX_GRAM)) begin
      gram_len_d = cfg_data_i;
      fill_d     = '0;
    end
  end

  assign emit = in_acc && (have_gram || end_of_string_i);

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_len_q  <= GLEN_RESET;
      partial_q   <= '0;
      exp_q       <= 2'd0;
      seq_q       <= SEQ_NONE;
      fill_q      <= '0;
      prev_sp_q   <= 1'b0;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gram_len_q  <= gram_len_d;
      partial_q   <= partial_d;
      exp_q       <= exp_d;
      seq_q       <= seq_d;
      fill_q      <= fill_d;
      prev_sp_q   <= prev_sp_d;
      aborted_q   <= aborted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // window contents and result payload
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (in_acc) begin
      gram_valid_q <= have_gram;
      out_cp_q     <= gram_cp;
      done_q       <= end_of_string_i;
      failed_q     <= failed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gram_valid_o    = gram_valid_q;
  assign code_point_0_o  = out_cp_q[0];
  assign code_point_1_o  = out_cp_q[1];
  assign code_point_2_o  = out_cp_q[2];
  assign code_point_3_o  = out_cp_q[3];
  assign code_point_4_o  = out_cp_q[4];
  assign code_point_5_o  = out_cp_q[5];
  assign string_done_o   = done_q;
  assign decode_failed_o = failed_q;

  // checks
  `UCNE_ASSERT(a_fill_below_len, clk_i, rst_ni,
               (gram_len_q != '0) |-> (fill_q < gram_len_q), "window overfilled")
  `UCNE_ASSERT(a_fail_needs_done, clk_i, rst_ni,
               out_valid_o |-> (!decode_failed_o || string_done_o), "failure without end")
  `UCNE_ASSERT(a_gram_nonzero, clk_i, rst_ni,
               (out_valid_o && gram_valid_o) |-> (code_point_0_o != '0), "zero code point in gram")
  `UCNE_ASSERT(a_eos_clears, clk_i, rst_ni,
               (in_acc && end_of_string_i && !cfg_valid_i) |=>
               (exp_q == 2'd0 && !aborted_q && fill_q == '0), "string state not cleared")
  `UCNE_ASSERT(a_seq_open, clk_i, rst_ni,
               (exp_q != 2'd0) |-> (seq_q == SEQ_TWO || seq_q == SEQ_THREE || seq_q == SEQ_FOUR),
               "open sequence without length")

endmodule
